// ----- sv/csv_field_record_splitter_macros.svh -----
// ----------------------------------------------------------------------------
// csv field and record splitter assertion macros
// shared concurrent assertion forms, clocked on clock
// ----------------------------------------------------------------------------
`ifndef CSV_FIELD_RECORD_SPLITTER_MACROS_SVH
`define CSV_FIELD_RECORD_SPLITTER_MACROS_SVH

// same-cycle implication, off while reset is high
`define CSVFS_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("csv splitter check failed");

// next-cycle implication, off while reset is high
`define CSVFS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("csv splitter check failed");

// next-cycle implication that also holds through reset
`define CSVFS_ASSERT_NEXT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("csv splitter check failed");

`endif

// ----- sv/csvfs_pkg.sv -----
// ----------------------------------------------------------------------------
// csvfs_pkg
// types, character codes and the per-byte field parser step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csvfs_pkg;

   // character codes
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;

   // default depth of the result queue, at least two
   localparam int RSP_DEPTH_DEFAULT = 4;

   // parse phases
   typedef enum logic [2:0] {
      PH_START  = 3'd0,
      PH_PLAIN  = 3'd1,
      PH_QUOTED = 3'd2,
      PH_QSEEN  = 3'd3,
      PH_SKIP   = 3'd4
   } phase_type;

   // result kinds
   typedef enum logic [1:0] {
      KIND_BYTE   = 2'd0,
      KIND_FIELD  = 2'd1,
      KIND_RECORD = 2'd2
   } kind_type;

   // input action codes
   localparam logic ACT_DATA = 1'b0;
   localparam logic ACT_END  = 1'b1;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       last;
   } result_type;

   // results of one input item, up to two
   typedef struct packed {
      logic [1:0] count;
      result_type r0;
      result_type r1;
   } step_out_type;

   typedef struct packed {
      logic       emit;
      kind_type   kind;
      logic [7:0] data;
      phase_type  next_phase;
   } feed_type;

   // one byte other than LF, a held CR included
   function automatic feed_type feed(phase_type ph, logic [7:0] b);
      feed_type f;
      f.emit       = 1'b0;
      f.kind       = KIND_BYTE;
      f.data       = b;
      f.next_phase = ph;
      if (ph == PH_QUOTED) begin
         if (b == CH_QUOTE) begin
            f.next_phase = PH_QSEEN;
         end else begin
            f.emit = 1'b1;
         end
      end else if (ph == PH_QSEEN && b == CH_QUOTE) begin
         // doubled quote gives one quote
         f.emit       = 1'b1;
         f.data       = CH_QUOTE;
         f.next_phase = PH_QUOTED;
      end else if (b == CH_COMMA) begin
         f.emit       = 1'b1;
         f.kind       = KIND_FIELD;
         f.data       = 8'h00;
         f.next_phase = PH_START;
      end else begin
         case (ph)
            PH_PLAIN: begin
               f.emit = 1'b1;
            end
            PH_QSEEN: begin
               f.next_phase = PH_SKIP;
            end
            PH_SKIP: begin
               f.next_phase = PH_SKIP;
            end
            default: begin
               // field start, unused codes act the same
               if (b == CH_QUOTE) begin
                  f.next_phase = PH_QUOTED;
               end else begin
                  f.emit       = 1'b1;
                  f.next_phase = PH_PLAIN;
               end
            end
         endcase
      end
      return f;
   endfunction

endpackage

`default_nettype wire

// ----- sv/csvfs_parser.sv -----
// ----------------------------------------------------------------------------
// csvfs_parser
// parse state registers and the single-pass step for one input item
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csvfs_parser
   import csvfs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step_en,
   input  wire logic         action,
   input  wire logic [7:0]   data_byte,
   output step_out_type      step_out
);

   phase_type phase_ff, phase_in;
   logic      held_cr_ff, held_cr_in;
   logic      line_open_ff, line_open_in;
   logic      any_record_ff, any_record_in;

   feed_type   f_cr;
   feed_type   f_byte;
   phase_type  phase_mid;
   logic       emit_a;
   logic       emit_b;
   result_type res_a;
   result_type res_b;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_START;
         held_cr_ff    <= 1'b0;
         line_open_ff  <= 1'b0;
         any_record_ff <= 1'b0;
      end else if (step_en) begin
         phase_ff      <= phase_in;
         held_cr_ff    <= held_cr_in;
         line_open_ff  <= line_open_in;
         any_record_ff <= any_record_in;
      end
   end

   // held cr first, then the new byte
   always_comb begin
      f_cr      = feed(phase_ff, CH_CR);
      phase_mid = held_cr_ff ? f_cr.next_phase : phase_ff;
      f_byte    = feed(phase_mid, data_byte);
      emit_a    = held_cr_ff && f_cr.emit;
      emit_b    = (data_byte != CH_CR) && f_byte.emit;
      res_a     = '{kind: f_cr.kind, data: f_cr.data, last: !emit_b};
      res_b     = '{kind: f_byte.kind, data: f_byte.data, last: 1'b1};
   end

   // next state and results
   always_comb begin
      phase_in      = phase_ff;
      held_cr_in    = held_cr_ff;
      line_open_in  = line_open_ff;
      any_record_in = any_record_ff;
      step_out      = '0;
      step_out.r0   = '{kind: KIND_RECORD, data: 8'h00, last: 1'b1};
      step_out.r1   = res_b;
      if (action == ACT_END) begin
         // end of stream closes an open line or gives one empty record
         if (line_open_ff || held_cr_ff || !any_record_ff) begin
            step_out.count = 2'd1;
         end
         phase_in      = PH_START;
         held_cr_in    = 1'b0;
         line_open_in  = 1'b0;
         any_record_in = 1'b0;
      end else if (data_byte == CH_LF) begin
         step_out.count = 2'd1;
         phase_in       = PH_START;
         held_cr_in     = 1'b0;
         line_open_in   = 1'b0;
         any_record_in  = 1'b1;
      end else begin
         line_open_in = 1'b1;
         held_cr_in   = (data_byte == CH_CR);
         phase_in     = (data_byte == CH_CR) ? phase_mid : f_byte.next_phase;
         if (emit_a) begin
            step_out.r0    = res_a;
            step_out.count = emit_b ? 2'd2 : 2'd1;
         end else if (emit_b) begin
            step_out.r0    = res_b;
            step_out.count = 2'd1;
         end
      end
   end

endmodule

`default_nettype wire

// ----- sv/csvfs_rsp_fifo.sv -----
// ----------------------------------------------------------------------------
// csvfs_rsp_fifo
// result queue taking up to two items a cycle and giving one
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module csvfs_rsp_fifo
   import csvfs_pkg::*;
#(
   parameter int DEPTH = RSP_DEPTH_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire step_out_type               push,
   input  wire logic                       pop,
   output result_type                      head,
   output logic                            not_empty,
   output logic                            room_two,
   output logic [$clog2(DEPTH+1)-1:0]      level
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   result_type             slot_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       wr_ptr_nx;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   do_pop;

   function automatic logic [PTR_W-1:0] ptr_inc(logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   // pointer and fill count
   always_comb begin
      do_pop    = pop && (count_ff != '0);
      wr_ptr_nx = ptr_inc(wr_ptr_ff);
      wr_ptr_in = wr_ptr_ff;
      if (push.count == 2'd1) begin
         wr_ptr_in = wr_ptr_nx;
      end else if (push.count == 2'd2) begin
         wr_ptr_in = ptr_inc(wr_ptr_nx);
      end
      rd_ptr_in = do_pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push.count) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage writes
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push.r0;
      end
      if (push.count == 2'd2) begin
         slot_ff[wr_ptr_nx] <= push.r1;
      end
   end

   assign head      = slot_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign room_two  = (count_ff <= CNT_W'(DEPTH - 2));
   assign level     = count_ff;

endmodule

`default_nettype wire

// ----- sv/csv_field_record_splitter.sv -----
// ----------------------------------------------------------------------------
// csv_field_record_splitter
// splits a csv byte stream into content bytes, field ends and record ends
// ----------------------------------------------------------------------------
// usage
//   req channel: one item per text byte (req_tuser low, byte in req_tdata),
//   or an end-of-stream item (req_tuser high) that closes an open line and
//   returns the parser to its start state.
//   rsp channel: rsp_tuser holds the kind (content byte, end of field, end
//   of field and record), rsp_tdata the content byte, rsp_tlast marks the
//   final result caused by one input item. An item gives zero to two results.
//   path: an accepted item is held in the input register, then parsed, and
//   its results are written into the result queue that drives rsp.
//   throughput: one item per cycle while items give at most one result each;
//   the single result port drains one result a cycle, so an item that gives
//   two results holds the port for both. The input stage advances only while
//   the result queue has room for two results.
//   reset: synchronous; clears the parse state, the input register and the
//   result queue.
//   a stalled receiver fills the result queue and then holds off req_tready;
//   nothing is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "csv_field_record_splitter_macros.svh"

module csv_field_record_splitter
   import csvfs_pkg::*;
#(
   parameter int RSP_DEPTH = RSP_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tuser,   // [0] action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] out_byte
   output logic [1:0]       rsp_tuser,   // [1:0] kind
   output logic             rsp_tlast
);

   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   logic             in_valid_ff, in_valid_in;
   logic             in_action_ff;
   logic [7:0]       in_byte_ff;
   logic             req_fire;
   logic             step_fire;
   logic             room_two;
   logic             not_empty;
   logic [CNT_W-1:0] level;
   step_out_type     step_out;
   step_out_type     push;
   result_type       head;

   // input register
   assign step_fire   = in_valid_ff && room_two;
   assign req_tready  = !in_valid_ff || room_two;
   assign req_fire    = req_tvalid && req_tready;
   assign in_valid_in = req_fire || (in_valid_ff && !step_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_action_ff <= req_tuser;
         in_byte_ff   <= req_tdata;
      end
   end

   // parse step
   csvfs_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step_en   (step_fire),
      .action    (in_action_ff),
      .data_byte (in_byte_ff),
      .step_out  (step_out)
   );

   // only a firing step pushes results
   always_comb begin
      push = step_out;
      if (!step_fire) begin
         push.count = 2'd0;
      end
   end

   csvfs_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_tready),
      .head      (head),
      .not_empty (not_empty),
      .room_two  (room_two),
      .level     (level)
   );

   assign rsp_tvalid = not_empty;
   assign rsp_tdata  = head.data;
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;

   // checks
   `CSVFS_ASSERT_IMPLY(a_level_bound, 1'b1, level <= CNT_W'(RSP_DEPTH))
   `CSVFS_ASSERT_NEXT(a_push_shows, step_fire && step_out.count != 2'd0, rsp_tvalid)
   `CSVFS_ASSERT_NEXT_ALWAYS(a_reset_empty, reset, !rsp_tvalid && !in_valid_ff)
   `CSVFS_ASSERT_IMPLY(a_stage_room, in_valid_ff && !room_two, !req_tready)

endmodule

`default_nettype wire
